@@ hdl/base64url_stream_encoder_top_defines.svh @@
// ----------------------------------------------------------------------------
// base64url stream encoder assertion macros
// shared property wrappers, empty when synthesised
// ----------------------------------------------------------------------------
`ifndef BASE64URL_STREAM_ENCODER_TOP_DEFINES_SVH
`define BASE64URL_STREAM_ENCODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define B64U_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64u assertion failed");

// next-cycle implication
`define B64U_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64u assertion failed");

`else

`define B64U_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define B64U_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/b64u_pkg.sv @@
// ----------------------------------------------------------------------------
// b64u_pkg
// types, codes and the alphabet lookup of the base64url stream encoder
// ----------------------------------------------------------------------------
package b64u_pkg;

    localparam int unsigned B64U_QUEUE_DEPTH = 2;

    localparam logic [6:0] PAD_CHAR = 7'h3D;

    // group kinds
    localparam logic [1:0] KIND_FULL = 2'd0;
    localparam logic [1:0] KIND_ONE  = 2'd1;
    localparam logic [1:0] KIND_TWO  = 2'd2;

    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  kind;
        logic        last;
    } b64u_grp_t;

    function automatic logic [6:0] b64u_sym(input logic [5:0] v);
        logic [6:0] code;
        if (v < 6'd26)
        begin
            code = 7'h41 + {1'b0, v};
        end
        else if (v < 6'd52)
        begin
            code = 7'h47 + {1'b0, v};
        end
        else if (v < 6'd62)
        begin
            code = {1'b0, v} - 7'd4;
        end
        else if (v == 6'd62)
        begin
            code = 7'h2D;
        end
        else
        begin
            code = 7'h5F;
        end
        return code;
    endfunction

endpackage

@@ hdl/b64u_front.sv @@
// ----------------------------------------------------------------------------
// b64u_front
// takes bytes, holds an open group and posts finished groups to the queue
// ----------------------------------------------------------------------------
`include "base64url_stream_encoder_top_defines.svh"

module b64u_front
    import b64u_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        end_of_message,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        q_full,
    output logic        push,
    output b64u_grp_t   push_grp
);

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [7:0] hold_hi_reg;
    logic [7:0] hold_lo_reg;
    logic       accept;
    logic       group_done;

    assign in_stall   = q_full;
    assign accept     = in_valid && !q_full;
    assign group_done = (cnt_reg == 2'd2) || end_of_message;
    assign push       = accept && group_done;

    always_comb
    begin
        push_grp.last = end_of_message;
        case (cnt_reg)
            2'd2:
            begin
                push_grp.bits = {hold_hi_reg, hold_lo_reg, data_byte};
                push_grp.kind = KIND_FULL;
            end
            2'd1:
            begin
                push_grp.bits = {hold_lo_reg, data_byte, 8'h00};
                push_grp.kind = KIND_TWO;
            end
            default:
            begin
                push_grp.bits = {data_byte, 16'h0000};
                push_grp.kind = KIND_ONE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            cnt_next = group_done ? 2'd0 : cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !group_done)
        begin
            hold_hi_reg <= hold_lo_reg;
            hold_lo_reg <= data_byte;
        end
    end

    `B64U_ASSERT_IMPLIES(a_front_cnt_range, clk, rst_n, 1'b1, cnt_reg != 2'd3)

endmodule

@@ hdl/b64u_queue.sv @@
// ----------------------------------------------------------------------------
// b64u_queue
// short group queue between the byte front end and the character back end
// ----------------------------------------------------------------------------
`include "base64url_stream_encoder_top_defines.svh"

module b64u_queue
    import b64u_pkg::*;
#(
    parameter int unsigned DEPTH = B64U_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  b64u_grp_t push_grp,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output b64u_grp_t head_grp
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    b64u_grp_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_grp   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_grp;
        end
    end

    `B64U_ASSERT_IMPLIES(a_queue_no_overflow, clk, rst_n, full, !push)
    `B64U_ASSERT_IMPLIES(a_queue_no_underflow, clk, rst_n, !head_valid, !pop)

endmodule

@@ hdl/b64u_back.sv @@
// ----------------------------------------------------------------------------
// b64u_back
// turns one queued group into four characters, one transfer per cycle while out_stall is low
// ----------------------------------------------------------------------------
`include "base64url_stream_encoder_top_defines.svh"

module b64u_back
    import b64u_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  b64u_grp_t   head_grp,
    output logic        pop,
    output logic [6:0]  char_code,
    output logic        last_char,
    output logic        out_valid,
    input  logic        out_stall
);

    b64u_grp_t  cur_reg;
    logic       cur_valid_reg;
    logic       cur_valid_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [6:0] char_reg;
    logic       last_reg;
    logic       out_load;
    logic       emit;
    logic       cur_done;
    logic [6:0] char_sel;

    assign out_load = !out_valid_reg || !out_stall;
    assign emit     = out_load && cur_valid_reg;
    assign cur_done = emit && (idx_reg == 2'd3);
    assign pop      = head_valid && (!cur_valid_reg || cur_done);

    assign char_code = char_reg;
    assign last_char = last_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        case (idx_reg)
            2'd0:    char_sel = b64u_sym(cur_reg.bits[23:18]);
            2'd1:    char_sel = b64u_sym(cur_reg.bits[17:12]);
            2'd2:    char_sel = (cur_reg.kind == KIND_ONE) ? PAD_CHAR
                                                           : b64u_sym(cur_reg.bits[11:6]);
            default: char_sel = (cur_reg.kind != KIND_FULL) ? PAD_CHAR
                                                            : b64u_sym(cur_reg.bits[5:0]);
        endcase
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = cur_valid_reg;
        end
        if (emit)
        begin
            idx_next = idx_reg + 2'd1;
        end
        if (pop)
        begin
            cur_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
        else if (cur_done)
        begin
            cur_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head_grp;
        end
        if (emit)
        begin
            char_reg <= char_sel;
            last_reg <= (idx_reg == 2'd3) && cur_reg.last;
        end
    end

    `B64U_ASSERT_NEXT(a_back_emit_shows, clk, rst_n, emit, out_valid_reg)

endmodule

@@ hdl/base64url_stream_encoder_top.sv @@
// a closing byte goes through a queue entry, the group register and the output register
// one byte per cycle while the queue has room, one character per cycle unless out_stall
// sustained byte rate is set by the single-character output register
// each closed group occupies the character back end for its four characters
// reset: asynchronous, clears the open group, the queue and the output register
// ----------------------------------------------------------------------------
// base64url_stream_encoder_top
// byte stream to url-safe base64 characters with padding and end marking
// ----------------------------------------------------------------------------
module base64url_stream_encoder_top
    import b64u_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = B64U_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        end_of_message,
    input  logic        in_valid,
    output logic        in_stall,
    output logic [6:0]  char_code,
    output logic        last_char,
    output logic        out_valid,
    input  logic        out_stall
);

    logic      push;
    b64u_grp_t push_grp;
    logic      q_full;
    logic      pop;
    logic      head_valid;
    b64u_grp_t head_grp;

    b64u_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .q_full         (q_full),
        .push           (push),
        .push_grp       (push_grp)
    );

    b64u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_grp   (push_grp),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_grp   (head_grp)
    );

    b64u_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_grp   (head_grp),
        .pop        (pop),
        .char_code  (char_code),
        .last_char  (last_char),
        .out_valid  (out_valid),
        .out_stall  (out_stall)
    );

endmodule
